// ===== design/crmsp_pkg.sv =====
package crmsp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRAD_MOM  = 3'd0,
    REG_SQ_MOM    = 3'd1,
    REG_DELTA_MOM = 3'd2,
    REG_LRATE     = 3'd3,
    REG_EPSILON   = 3'd4
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [15:0] GRAD_MOM_RST  = 16'd62259;
  localparam logic [15:0] SQ_MOM_RST    = 16'd62259;
  localparam logic [15:0] DELTA_MOM_RST = 16'd58982;
  localparam logic [23:0] LRATE_RST     = 24'd1678;
  localparam logic [23:0] EPSILON_RST   = 24'd1678;

  // Input queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Iteration counts of the root and divide units
  localparam logic [5:0] SQRT_STEPS = 6'd29;
  localparam logic [5:0] DIV_STEPS  = 6'd56;

  typedef struct packed {
    logic [15:0] grad_mom;
    logic [15:0] sq_mom;
    logic [15:0] delta_mom;
    logic [23:0] lrate;
    logic [23:0] epsilon;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_M8,
    S_SQRT,
    S_DSET,
    S_DIV,
    S_FIN
  } back_state_e;

endpackage

// ===== design/crmsp_front.sv =====
module crmsp_front #(
  parameter int unsigned LAYERS            = 4,
  parameter int unsigned WEIGHTS_PER_LAYER = 1024,
  parameter int unsigned AW                = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [2:0]           layer_number_i,
  input  logic [9:0]           weight_index_i,
  input  logic signed [31:0]   gradient_i,
  output logic                 full_o,
  output logic                 deq_valid_o,
  output logic                 deq_ok_o,
  output logic [AW-1:0]        deq_addr_o,
  output logic signed [31:0]   deq_grad_o,
  input  logic                 pop_i
);

  localparam int unsigned PW = crmsp_pkg::QueuePtrW;

  logic            ok_mem   [crmsp_pkg::QueueDepth];
  logic [AW-1:0]   addr_mem [crmsp_pkg::QueueDepth];
  logic [31:0]     grad_mem [crmsp_pkg::QueueDepth];

  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;
  logic            in_range;
  logic [31:0]     lin_addr;

  // Classify: range check and linear address
  always_comb begin
    in_range = (layer_number_i != 3'd0) && (32'(layer_number_i) <= 32'(LAYERS))
               && (32'(weight_index_i) < 32'(WEIGHTS_PER_LAYER));
    lin_addr = (32'(layer_number_i) - 32'd1) * 32'(WEIGHTS_PER_LAYER)
               + 32'(weight_index_i);
  end

  assign full_o      = (count_q == (PW+1)'(crmsp_pkg::QueueDepth));
  assign deq_valid_o = (count_q != '0);
  assign deq_ok_o    = ok_mem[rd_ptr_q];
  assign deq_addr_o  = addr_mem[rd_ptr_q];
  assign deq_grad_o  = signed'(grad_mem[rd_ptr_q]);

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ok_mem[wr_ptr_q]   <= in_range;
      addr_mem[wr_ptr_q] <= lin_addr[AW-1:0];
      grad_mem[wr_ptr_q] <= gradient_i;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      count_q <= count_q + (PW+1)'(1);
      else if (!push_i && pop_i) count_q <= count_q - (PW+1)'(1);
    end
  end

endmodule

// ===== design/crmsp_back.sv =====
module crmsp_back #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crmsp_pkg::cfg_t      cfg_i,
  input  logic                 deq_valid_i,
  input  logic                 deq_ok_i,
  input  logic [AW-1:0]        deq_addr_i,
  input  logic signed [31:0]   deq_grad_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 res_valid_o,
  output logic signed [31:0]   res_delta_o
);

  localparam logic [5:0] SQRT_LAST = crmsp_pkg::SQRT_STEPS - 6'd1;
  localparam logic [5:0] DIV_LAST  = crmsp_pkg::DIV_STEPS - 6'd1;

  crmsp_pkg::back_state_e state_q, state_d;

  // Per-element stores
  logic [31:0] mg_mem [DEPTH];
  logic [31:0] ms_mem [DEPTH];
  logic [31:0] pd_mem [DEPTH];
  logic [31:0] mg_rd_q, ms_rd_q, pd_rd_q;

  logic [AW-1:0]        addr_q, clr_cnt_q, clr_cnt_d;
  logic signed [31:0]   g_q;
  logic signed [63:0]   p_q, t1_q;
  logic signed [31:0]   mg_q;
  logic [31:0]          sq_q, msq_q;
  logic signed [32:0]   dterm_q;
  logic [57:0]          v_q, res_q, bit_q;
  logic [28:0]          root_q, rem_q;
  logic [55:0]          dq_q;
  logic                 neg_q;
  logic [5:0]           cnt_q;
  logic                 rv_q;
  logic signed [31:0]   rd_q;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  logic signed [32:0]   g_abs, mg_abs;
  logic signed [63:0]   sum_mg, sum_dt;
  logic [63:0]          sum_ms, sq64;
  logic signed [41:0]   rad;
  logic [57:0]          sq_sum;
  logic [29:0]          rem_sh;
  logic signed [57:0]   step, dfull;
  logic signed [31:0]   d_sat;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;

  assign g_abs  = g_q[31]  ? -33'(g_q)  : 33'(g_q);
  assign mg_abs = mg_q[31] ? -33'(mg_q) : 33'(mg_q);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      crmsp_pkg::S_M1: begin
        mul_a = signed'({17'd0, cfg_i.grad_mom});
        mul_b = 33'(signed'(mg_rd_q));
      end
      crmsp_pkg::S_M2: begin
        mul_a = signed'(33'(17'h10000 - {1'b0, cfg_i.grad_mom}));
        mul_b = 33'(g_q);
      end
      crmsp_pkg::S_M3: begin
        mul_a = g_abs;
        mul_b = g_abs;
      end
      crmsp_pkg::S_M4: begin
        mul_a = signed'({17'd0, cfg_i.sq_mom});
        mul_b = signed'({1'b0, ms_rd_q});
      end
      crmsp_pkg::S_M5: begin
        mul_a = signed'(33'(17'h10000 - {1'b0, cfg_i.sq_mom}));
        mul_b = signed'({1'b0, sq_q});
      end
      crmsp_pkg::S_M6: begin
        mul_a = mg_abs;
        mul_b = mg_abs;
      end
      crmsp_pkg::S_M7: begin
        mul_a = signed'({17'd0, cfg_i.delta_mom});
        mul_b = 33'(signed'(pd_rd_q));
      end
      crmsp_pkg::S_M8: begin
        mul_a = signed'({9'd0, cfg_i.lrate});
        mul_b = 33'(g_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding, saturation and radicand
  always_comb begin
    sum_mg = t1_q + p_q + 64'sd32768;
    sum_ms = 64'(t1_q) + 64'(p_q) + 64'd32768;
    sum_dt = p_q + 64'sd32768;
    sq64   = (64'(p_q) + 64'd8388608) >> 24;
    rad    = signed'(42'({10'd0, msq_q})) - signed'({2'b0, sq64[39:0]})
             + signed'({18'd0, cfg_i.epsilon});
    sq_sum = res_q + bit_q;
    rem_sh = {rem_q, dq_q[55]};
    step   = neg_q ? -58'(signed'({1'b0, dq_q})) : 58'(signed'({1'b0, dq_q}));
    dfull  = 58'(dterm_q) - step;
    if (dfull > 58'sd2147483647)        d_sat = 32'sh7FFFFFFF;
    else if (dfull < -58'sd2147483648)  d_sat = 32'sh80000000;
    else                                d_sat = dfull[31:0];
  end

  // Next state and control
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = addr_q;
    case (state_q)
      crmsp_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) state_d = crmsp_pkg::S_IDLE;
      end
      crmsp_pkg::S_IDLE: begin
        if (deq_valid_i) begin
          pop_o = 1'b1;
          if (deq_ok_i) state_d = crmsp_pkg::S_READ;
        end
      end
      crmsp_pkg::S_READ: state_d = crmsp_pkg::S_M1;
      crmsp_pkg::S_M1:   state_d = crmsp_pkg::S_M2;
      crmsp_pkg::S_M2:   state_d = crmsp_pkg::S_M3;
      crmsp_pkg::S_M3:   state_d = crmsp_pkg::S_M4;
      crmsp_pkg::S_M4:   state_d = crmsp_pkg::S_M5;
      crmsp_pkg::S_M5:   state_d = crmsp_pkg::S_M6;
      crmsp_pkg::S_M6:   state_d = crmsp_pkg::S_M7;
      crmsp_pkg::S_M7:   state_d = crmsp_pkg::S_M8;
      crmsp_pkg::S_M8:   state_d = crmsp_pkg::S_SQRT;
      crmsp_pkg::S_SQRT: begin
        if (cnt_q == SQRT_LAST) state_d = crmsp_pkg::S_DSET;
      end
      crmsp_pkg::S_DSET: begin
        if (res_q[28:0] == '0) state_d = crmsp_pkg::S_FIN;
        else                   state_d = crmsp_pkg::S_DIV;
      end
      crmsp_pkg::S_DIV: begin
        if (cnt_q == DIV_LAST) state_d = crmsp_pkg::S_FIN;
      end
      crmsp_pkg::S_FIN: begin
        mem_we  = 1'b1;
        state_d = crmsp_pkg::S_IDLE;
      end
      default: state_d = crmsp_pkg::S_IDLE;
    endcase
  end

  // Store write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mg_mem[mem_wa] <= (state_q == crmsp_pkg::S_CLEAR) ? 32'd0 : mg_q;
      ms_mem[mem_wa] <= (state_q == crmsp_pkg::S_CLEAR) ? 32'd0 : msq_q;
      pd_mem[mem_wa] <= (state_q == crmsp_pkg::S_CLEAR) ? 32'd0 : d_sat;
    end
    mg_rd_q <= mg_mem[addr_q];
    ms_rd_q <= ms_mem[addr_q];
    pd_rd_q <= pd_mem[addr_q];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      crmsp_pkg::S_IDLE: begin
        addr_q <= deq_addr_i;
        g_q    <= deq_grad_i;
      end
      crmsp_pkg::S_M1: p_q <= mul_p[63:0];
      crmsp_pkg::S_M2: begin
        t1_q <= p_q;
        p_q  <= mul_p[63:0];
      end
      crmsp_pkg::S_M3: begin
        mg_q <= sum_mg[47:16];
        p_q  <= mul_p[63:0];
      end
      crmsp_pkg::S_M4: begin
        sq_q <= (sq64[63:32] != '0) ? 32'hFFFFFFFF : sq64[31:0];
        p_q  <= mul_p[63:0];
      end
      crmsp_pkg::S_M5: begin
        t1_q <= p_q;
        p_q  <= mul_p[63:0];
      end
      crmsp_pkg::S_M6: begin
        msq_q <= (sum_ms[63:48] != '0) ? 32'hFFFFFFFF : sum_ms[47:16];
        p_q   <= mul_p[63:0];
      end
      crmsp_pkg::S_M7: begin
        v_q <= rad[41] ? 58'd0 : {1'b0, rad[32:0], 24'd0};
        p_q <= mul_p[63:0];
      end
      crmsp_pkg::S_M8: begin
        dterm_q <= sum_dt[48:16];
        p_q     <= mul_p[63:0];
        res_q   <= '0;
        bit_q   <= 58'd1 << 56;
      end
      crmsp_pkg::S_SQRT: begin
        // one result bit per cycle
        if (v_q >= sq_sum) begin
          v_q   <= v_q - sq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      crmsp_pkg::S_DSET: begin
        root_q <= res_q[28:0];
        rem_q  <= '0;
        neg_q  <= p_q[63];
        if (res_q[28:0] == '0) begin
          // zero root: step of two to the fortieth, or zero for a zero product
          dq_q <= (p_q == '0) ? 56'd0 : (56'd1 << 40);
        end else begin
          dq_q <= p_q[63] ? 56'(-p_q) : p_q[55:0];
        end
      end
      crmsp_pkg::S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {1'b0, root_q}) begin
          rem_q <= 29'(rem_sh - {1'b0, root_q});
          dq_q  <= {dq_q[54:0], 1'b1};
        end else begin
          rem_q <= rem_sh[28:0];
          dq_q  <= {dq_q[54:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crmsp_pkg::S_CLEAR;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      rd_q      <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (state_q == crmsp_pkg::S_SQRT || state_q == crmsp_pkg::S_DIV) begin
        cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : 6'd0;
      end else begin
        cnt_q <= '0;
      end
      rv_q <= 1'b0;
      if (state_q == crmsp_pkg::S_IDLE && deq_valid_i && !deq_ok_i) begin
        rv_q <= 1'b1;
        rd_q <= '0;
      end else if (state_q == crmsp_pkg::S_FIN) begin
        rv_q <= 1'b1;
        rd_q <= d_sat;
      end
    end
  end

  assign clearing_o  = (state_q == crmsp_pkg::S_CLEAR);
  assign res_valid_o = rv_q;
  assign res_delta_o = rd_q;

endmodule

// ===== design/centered_rmsprop_update.sv =====
// Centered RMSProp weight update, one gradient per command.
// Command channel: an item (layer_number_i, weight_index_i, gradient_i) is
// taken at a clock edge with start high and busy low. Items enter a
// four-beat queue; busy rises when the queue is full or while the stores
// are being cleared.
// Result channel: result_valid_o pulses for one cycle with weight_delta_o.
// The receiver cannot stall; results come out in command order.
// Processing: the back end works on one item at a time. An in-range item
// passes through a store read, the shared-multiplier steps, the bit-serial
// square root and the restoring divider, then a write-back; the divider
// is skipped when the root is zero. An out-of-range item is answered
// from the idle state with a zero delta and no store access.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes one
// register; cfg_ready_o is always high. Write only while idle.
// Reset: registers take their defaults and a clearing pass over all
// LAYERS * WEIGHTS_PER_LAYER entries zeroes the three stores; busy is
// high during that pass.
module centered_rmsprop_update #(
  parameter int unsigned LAYERS            = 4,
  parameter int unsigned WEIGHTS_PER_LAYER = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          layer_number_i,
  input  logic [9:0]          weight_index_i,
  input  logic signed [31:0]  gradient_i,
  output logic                result_valid_o,
  output logic signed [31:0]  weight_delta_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i
);

  localparam int unsigned DEPTH = LAYERS * WEIGHTS_PER_LAYER;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crmsp_pkg::cfg_t     cfg_q;
  logic                full, clearing, pop;
  logic                deq_valid, deq_ok;
  logic [AW-1:0]       deq_addr;
  logic signed [31:0]  deq_grad;
  logic                push;

  assign cfg_ready_o = 1'b1;
  assign busy        = full || clearing;
  assign push        = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grad_mom  <= crmsp_pkg::GRAD_MOM_RST;
      cfg_q.sq_mom    <= crmsp_pkg::SQ_MOM_RST;
      cfg_q.delta_mom <= crmsp_pkg::DELTA_MOM_RST;
      cfg_q.lrate     <= crmsp_pkg::LRATE_RST;
      cfg_q.epsilon   <= crmsp_pkg::EPSILON_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crmsp_pkg::REG_GRAD_MOM:  cfg_q.grad_mom  <= cfg_data_i[15:0];
        crmsp_pkg::REG_SQ_MOM:    cfg_q.sq_mom    <= cfg_data_i[15:0];
        crmsp_pkg::REG_DELTA_MOM: cfg_q.delta_mom <= cfg_data_i[15:0];
        crmsp_pkg::REG_LRATE:     cfg_q.lrate     <= cfg_data_i;
        crmsp_pkg::REG_EPSILON:   cfg_q.epsilon   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crmsp_front #(
    .LAYERS            (LAYERS),
    .WEIGHTS_PER_LAYER (WEIGHTS_PER_LAYER),
    .AW                (AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .layer_number_i (layer_number_i),
    .weight_index_i (weight_index_i),
    .gradient_i     (gradient_i),
    .full_o         (full),
    .deq_valid_o    (deq_valid),
    .deq_ok_o       (deq_ok),
    .deq_addr_o     (deq_addr),
    .deq_grad_o     (deq_grad),
    .pop_i          (pop)
  );

  crmsp_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .deq_valid_i (deq_valid),
    .deq_ok_i    (deq_ok),
    .deq_addr_i  (deq_addr),
    .deq_grad_i  (deq_grad),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (result_valid_o),
    .res_delta_o (weight_delta_o)
  );

endmodule

// ===== test/centered_rmsprop_update_tb.sv =====
`timescale 1ns / 100ps

module centered_rmsprop_update_tb;

  localparam int unsigned NumLayers = 4;
  localparam int unsigned NumWeights = 1024;
  localparam int unsigned Depth = NumLayers * NumWeights;
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandPhases = 6;
  localparam int unsigned RandPerPhase = 105;

  typedef struct {
    int unsigned       ph;
    logic [2:0]        layer;
    logic [9:0]        widx;
    logic signed [31:0] grad;
    bit                known;
    logic signed [31:0] delta;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] layer_number_i = '0;
  logic [9:0] weight_index_i = '0;
  logic signed [31:0] gradient_i = '0;
  logic result_valid_o;
  logic signed [31:0] weight_delta_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // predictor state
  crmsp_pkg::cfg_t cfg_mdl;
  logic signed [31:0] mean_grad_mdl [Depth];
  logic [31:0] mean_sq_mdl [Depth];
  logic signed [31:0] prev_delta_mdl [Depth];

  logic signed [31:0] delta_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  dir_row_t dir_rows [$];

  centered_rmsprop_update dut (
    .clk_i, .rst_ni, .start, .busy,
    .layer_number_i, .weight_index_i, .gradient_i,
    .result_valid_o, .weight_delta_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (delta_q.size() == 0) begin
        $display("%0t unexpected weight_delta beat: got %h", $time, weight_delta_o);
        errors++;
      end else begin
        if (weight_delta_o !== delta_q[0]) begin
          $display("%0t weight_delta mismatch: exp %h got %h", $time, delta_q[0],
                   weight_delta_o);
          errors++;
        end
        void'(delta_q.pop_front());
      end
    end
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] square_q24(longint x);
    logic [63:0] mag;
    mag = (x < 0) ? -x : x;
    return (mag * mag + 64'd8388608) >> 24;
  endfunction

  // centered RMSProp step for one weight, updates the stores
  function automatic logic signed [31:0] rmsprop_delta(logic [2:0] ly, logic [9:0] wi,
                                                       logic signed [31:0] gr);
    longint g, gm, mg, rad, prod, step, d;
    logic [63:0] sq, msq, root;
    int unsigned addr;
    if (ly < 1 || ly > NumLayers) return '0;
    addr = (ly - 1) * NumWeights + wi;
    g = gr;
    gm = longint'(cfg_mdl.grad_mom);
    mg = (gm * longint'(mean_grad_mdl[addr]) + (65536 - gm) * g + 32768) >>> 16;
    mean_grad_mdl[addr] = mg[31:0];
    sq = square_q24(g);
    if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
    msq = (64'(cfg_mdl.sq_mom) * 64'(mean_sq_mdl[addr])
           + (64'd65536 - 64'(cfg_mdl.sq_mom)) * sq + 64'd32768) >> 16;
    if (msq > 64'hFFFF_FFFF) msq = 64'hFFFF_FFFF;
    mean_sq_mdl[addr] = msq[31:0];
    rad = longint'(msq) - longint'(square_q24(mg)) + longint'(cfg_mdl.epsilon);
    if (rad < 0) rad = 0;
    root = isqrt64(64'(rad) << 24);
    prod = longint'(cfg_mdl.lrate) * g;
    if (root == 0) step = (prod > 0) ? (64'sd1 <<< 40) : ((prod < 0) ? -(64'sd1 <<< 40) : 0);
    else step = prod / longint'(root);
    d = ((longint'(cfg_mdl.delta_mom) * longint'(prev_delta_mdl[addr]) + 32768) >>> 16)
        - step;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    prev_delta_mdl[addr] = d[31:0];
    return d[31:0];
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      crmsp_pkg::REG_GRAD_MOM:  cfg_mdl.grad_mom = data[15:0];
      crmsp_pkg::REG_SQ_MOM:    cfg_mdl.sq_mom = data[15:0];
      crmsp_pkg::REG_DELTA_MOM: cfg_mdl.delta_mom = data[15:0];
      crmsp_pkg::REG_LRATE:     cfg_mdl.lrate = data;
      crmsp_pkg::REG_EPSILON:   cfg_mdl.epsilon = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic cfg_all(logic [15:0] gm, logic [15:0] sm, logic [15:0] dm,
                         logic [23:0] lr, logic [23:0] ep);
    cfg_write(crmsp_pkg::REG_GRAD_MOM, 24'(gm));
    cfg_write(crmsp_pkg::REG_SQ_MOM, 24'(sm));
    cfg_write(crmsp_pkg::REG_DELTA_MOM, 24'(dm));
    cfg_write(crmsp_pkg::REG_LRATE, lr);
    cfg_write(crmsp_pkg::REG_EPSILON, ep);
  endtask

  // wait until every delta is back, then let the back end settle
  task automatic drain();
    start = 1'b0;
    while (delta_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // one command beat; returns at the falling edge after acceptance, start still high
  task automatic send_grad(logic [2:0] ly, logic [9:0] wi, logic signed [31:0] gr,
                           int unsigned gap, bit known, logic signed [31:0] kdelta);
    logic signed [31:0] pd;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    layer_number_i = ly;
    weight_index_i = wi;
    gradient_i = gr;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    pd = rmsprop_delta(ly, wi, gr);
    delta_q.push_back(known ? kdelta : pd);
    @(negedge clk_i);
  endtask

  task automatic dir_phase_cfg(int unsigned ph);
    case (ph)
      1: cfg_all(16'd0, 16'd0, 16'd65535, 24'hFF_FFFF, 24'd0);
      2: cfg_all(16'd0, 16'd65535, 16'd0, 24'd1678, 24'd0);
      default: ;
    endcase
  endtask

  task automatic add_row(int unsigned ph, logic [2:0] ly, logic [9:0] wi,
                         logic signed [31:0] gr, bit known, logic signed [31:0] dl);
    dir_row_t r;
    r.ph = ph; r.layer = ly; r.widx = wi; r.grad = gr; r.known = known; r.delta = dl;
    dir_rows.push_back(r);
  endtask

  initial begin
    int unsigned cur_ph, gap;
    bit burst;
    logic [2:0] ly;
    logic [9:0] wi;
    logic signed [31:0] gr;

    cfg_mdl = '{crmsp_pkg::GRAD_MOM_RST, crmsp_pkg::SQ_MOM_RST, crmsp_pkg::DELTA_MOM_RST,
                crmsp_pkg::LRATE_RST, crmsp_pkg::EPSILON_RST};
    for (int i = 0; i < Depth; i++) begin
      mean_grad_mdl[i] = '0;
      mean_sq_mdl[i] = '0;
      prev_delta_mdl[i] = '0;
    end

    // defaults after reset; out-of-range layers give zero
    add_row(0, 3'd1, 10'd0, 32'sh0000_0000, 1, 32'sh0);
    add_row(0, 3'd0, 10'd5, 32'sh7FFF_FFFF, 1, 32'sh0);
    add_row(0, 3'd5, 10'd9, 32'sh0100_0000, 1, 32'sh0);
    add_row(0, 3'd7, 10'd1023, 32'sh8000_0000, 1, 32'sh0);
    add_row(0, 3'd1, 10'd1023, 32'sh7FFF_FFFF, 0, 32'sh0);
    add_row(0, 3'd1, 10'd1, 32'sh8000_0000, 0, 32'sh0);
    add_row(0, 3'd4, 10'd1023, 32'sh0000_0001, 0, 32'sh0);
    add_row(0, 3'd1, 10'd1023, 32'sh7FFF_FFFF, 0, 32'sh0);
    add_row(0, 3'd2, 10'd7, 32'shFFFF_FFFF, 0, 32'sh0);
    // no decay and no epsilon: zero root saturates the delta
    add_row(1, 3'd2, 10'd0, 32'sh0100_0000, 1, 32'sh8000_0000);
    add_row(1, 3'd2, 10'd1, 32'shFF00_0000, 1, 32'sh7FFF_FFFF);
    add_row(1, 3'd2, 10'd2, 32'sh0000_0000, 1, 32'sh0);
    add_row(1, 3'd2, 10'd3, 32'sh8000_0000, 0, 32'sh0);
    add_row(1, 3'd2, 10'd0, 32'sh0100_0000, 0, 32'sh0);
    // slow square mean: negative radicand clamps to zero
    add_row(2, 3'd3, 10'd0, 32'sh0100_0000, 1, 32'sh8000_0000);
    add_row(2, 3'd3, 10'd1, 32'sh7FFF_FFFF, 0, 32'sh0);
    add_row(2, 3'd3, 10'd2, 32'sh8000_0000, 0, 32'sh0);
    add_row(2, 3'd3, 10'd1, 32'sh0000_1234, 0, 32'sh0);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // unknown index is ignored
    cfg_write(REG_UNUSED, 24'hFF_FFFF);

    cur_ph = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].ph != cur_ph) begin
        drain();
        cur_ph = dir_rows[i].ph;
        dir_phase_cfg(cur_ph);
      end
      send_grad(dir_rows[i].layer, dir_rows[i].widx, dir_rows[i].grad,
                $urandom_range(0, 3), dir_rows[i].known, dir_rows[i].delta);
    end

    // random phases, each under its own register setting
    burst = 0;
    for (int p = 0; p < RandPhases; p++) begin
      drain();
      case (p)
        0: cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        1: cfg_all(16'h0000, 16'h0000, 16'h0000, 24'h00_0000, 24'h00_0000);
        2: cfg_all(crmsp_pkg::GRAD_MOM_RST, crmsp_pkg::SQ_MOM_RST, crmsp_pkg::DELTA_MOM_RST,
                   crmsp_pkg::LRATE_RST, crmsp_pkg::EPSILON_RST);
        default: cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                         24'($urandom_range(0, 4096)));
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        if (n % 35 == 0) burst = $urandom_range(0, 2) == 0;
        // hold off once mid-phase until every delta is back
        if (p == 3 && n == 50) begin
          start = 1'b0;
          while (delta_q.size() != 0) @(negedge clk_i);
        end
        if ($urandom_range(0, 9) == 0) begin
          ly = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
        end else begin
          ly = 3'($urandom_range(1, NumLayers));
        end
        wi = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) gr = $urandom;
        else gr = 32'(int'($urandom_range(0, 33554432)) - 16777216);
        gap = burst ? 0 : $urandom_range(0, 14);
        send_grad(ly, wi, gr, gap, 0, 32'sh0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/crmsp_pkg.sv
design/crmsp_front.sv
design/crmsp_back.sv
design/centered_rmsprop_update.sv
test/centered_rmsprop_update_tb.sv
